FILE: hw/rtl/ccm_pkg.sv
// Shared types and constants for the click classifier with channel modes.
// Holds the transfer payload structs, the channel mode codes and register indexes.
// No dependencies.
package ccm_pkg;

   localparam int NumChannels = 4;
   localparam int NumButtons  = NumChannels + 1;
   localparam int EncButton   = NumChannels;

   localparam int TimeWidth   = 32;
   localparam int HoldWidth   = 16;
   localparam int VolWidth    = 7;
   localparam int PosWidth    = 16;
   localparam int CsrIdxWidth = 2;
   localparam int CsrWidth    = 16;

   localparam logic [CsrIdxWidth-1:0] RegLongPressMs = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegVolumeStep  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegVolumeMax   = 2'd2;

   localparam logic [HoldWidth-1:0] LongPressReset = 16'd400;
   localparam logic [VolWidth-1:0]  VolStepReset   = 7'd4;
   localparam logic [VolWidth-1:0]  VolMaxReset    = 7'd100;
   localparam logic [VolWidth-1:0]  VolumeReset    = 7'd50;

   typedef enum logic [1:0] {
      MODE_UNMUTED = 2'd0,
      MODE_MUTED   = 2'd1,
      MODE_SELECT  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [NumButtons-1:0] buttons_n;
      logic                  rotated;
      logic                  turn_up;
      logic [TimeWidth-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic [NumButtons-1:0]         short_clicks;
      logic [NumButtons-1:0]         long_clicks;
      logic [NumChannels-1:0]        led_on;
      logic [NumChannels-1:0]        select_mask;
      logic [NumChannels-1:0]        mute_events;
      logic [NumChannels-1:0]        unmute_events;
      logic                          select_active;
      logic [VolWidth-1:0]           volume_level;
      logic signed [PosWidth-1:0]    encoder_position;
   } rsp_type;

   typedef struct packed {
      logic [NumButtons-1:0] short_clicks;
      logic [NumButtons-1:0] long_clicks;
   } clicks_type;

endpackage

FILE: hw/rtl/ccm_buttons.sv
// Per-button press timing and short/long click classification.
// Depends on ccm_pkg for widths and the clicks_type struct.
module ccm_buttons (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [ccm_pkg::NumButtons-1:0]   buttons_n,
   input  logic [ccm_pkg::TimeWidth-1:0]    now_ms,
   input  logic [ccm_pkg::HoldWidth-1:0]    long_press_ms,
   output ccm_pkg::clicks_type              clicks
);

   logic [ccm_pkg::NumButtons-1:0] held_ff, held_in;
   logic [ccm_pkg::NumButtons-1:0] long_ff, long_in;
   logic [ccm_pkg::TimeWidth-1:0]  start_ff [ccm_pkg::NumButtons];
   logic [ccm_pkg::TimeWidth-1:0]  start_in [ccm_pkg::NumButtons];
   logic [ccm_pkg::TimeWidth-1:0]  start_eff [ccm_pkg::NumButtons];
   logic [ccm_pkg::TimeWidth-1:0]  elapsed [ccm_pkg::NumButtons];
   logic [ccm_pkg::NumButtons-1:0] over;

   always_comb begin
      clicks = '0;
      for (int i = 0; i < ccm_pkg::NumButtons; i++) begin
         // A fresh press starts its timer now, so it cannot be long yet.
         start_eff[i] = held_ff[i] ? start_ff[i] : now_ms;
         elapsed[i]   = now_ms - start_eff[i];
         over[i]      = elapsed[i] >
                        {{(ccm_pkg::TimeWidth - ccm_pkg::HoldWidth){1'b0}}, long_press_ms};
         held_in[i]   = held_ff[i];
         long_in[i]   = long_ff[i];
         start_in[i]  = start_ff[i];
         if (!buttons_n[i]) begin
            held_in[i]  = 1'b1;
            start_in[i] = start_eff[i];
            if (over[i] && !long_ff[i]) begin
               long_in[i] = 1'b1;
               clicks.long_clicks[i] = 1'b1;
            end
         end else if (held_ff[i]) begin
            // Release after a long click reports nothing.
            if (long_ff[i]) begin
               long_in[i] = 1'b0;
            end else begin
               clicks.short_clicks[i] = 1'b1;
            end
            held_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         long_ff <= '0;
      end else if (advance) begin
         held_ff <= held_in;
         long_ff <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         start_ff <= start_in;
      end
   end

endmodule

FILE: hw/rtl/click_classifier_channel_mode_unit.sv
// Top level of the click classifier with channel mute/select modes and encoder handling.
// Depends on ccm_pkg and instantiates ccm_buttons.
//
//   Channel  | Direction | Handshake               | Payload
//   ---------+-----------+-------------------------+------------------------------
//   req_     | in        | req_valid / req_ready   | req_data  (ccm_pkg::req_type)
//   rsp_     | out       | rsp_valid / rsp_ready   | rsp_data  (ccm_pkg::rsp_type)
//   csr_     | in        | csr_write (no wait)     | csr_index, csr_data
//
// Every polling pass yields exactly one result, via the input register then the result
// register. One pass per cycle is sustained while results are taken: the input register
// hands its pass to the result register through combinational logic, and both registers
// let a stalled result sit while one more pass is taken in. Reset is synchronous, active
// high; it restores the configuration defaults, held/long button flags and channel state.
module click_classifier_channel_mode_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ccm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ccm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_write,
   input  logic [ccm_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [ccm_pkg::CsrWidth-1:0]        csr_data
);

   // Input register stage.
   ccm_pkg::req_type in_ff;
   logic             in_valid_ff;

   // Result register stage.
   ccm_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff;

   // A pass moves from the input register to the result register when the
   // result register is empty or its content is transferred out this cycle.
   logic advance;
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Configuration registers.
   logic [ccm_pkg::HoldWidth-1:0] long_press_ff;
   logic [ccm_pkg::VolWidth-1:0]  vol_step_ff;
   logic [ccm_pkg::VolWidth-1:0]  vol_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= ccm_pkg::LongPressReset;
         vol_step_ff   <= ccm_pkg::VolStepReset;
         vol_max_ff    <= ccm_pkg::VolMaxReset;
      end else if (csr_write) begin
         unique case (csr_index)
            ccm_pkg::RegLongPressMs: long_press_ff <= csr_data;
            ccm_pkg::RegVolumeStep:  vol_step_ff   <= csr_data[ccm_pkg::VolWidth-1:0];
            ccm_pkg::RegVolumeMax:   vol_max_ff    <= csr_data[ccm_pkg::VolWidth-1:0];
            default: ;
         endcase
      end
   end

   // Button classification for the pass held in the input register.
   ccm_pkg::clicks_type clicks;

   ccm_buttons u_buttons (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .buttons_n     (in_ff.buttons_n),
      .now_ms        (in_ff.now_ms),
      .long_press_ms (long_press_ff),
      .clicks        (clicks)
   );

   // Channel and encoder state.
   ccm_pkg::mode_type               mode_ff [ccm_pkg::NumChannels];
   ccm_pkg::mode_type               mode_in [ccm_pkg::NumChannels];
   ccm_pkg::mode_type               prev_ff [ccm_pkg::NumChannels];
   ccm_pkg::mode_type               prev_eff [ccm_pkg::NumChannels];
   logic [ccm_pkg::NumChannels-1:0] led_ff, led_in;
   logic                            select_ff, select_in;
   logic [ccm_pkg::VolWidth-1:0]    volume_ff, volume_in;
   logic [ccm_pkg::PosWidth-1:0]    position_ff, position_in;

   logic [ccm_pkg::NumChannels-1:0] sel_mask, mutes, unmutes;
   logic                            enc_short;

   // Volume arithmetic is done two bits wider and signed so that the step can
   // push it below zero or past the bound before clamping.
   logic signed [ccm_pkg::VolWidth+1:0] vol_sum, vol_cur, vol_step, vol_bound;

   assign enc_short = clicks.short_clicks[ccm_pkg::EncButton];

   always_comb begin
      // Rotation first. The select flag seen here is the one left by the previous pass.
      vol_cur     = $signed({2'b00, volume_ff});
      vol_step    = $signed({2'b00, vol_step_ff});
      vol_bound   = $signed({2'b00, vol_max_ff});
      vol_sum     = in_ff.turn_up ? (vol_cur + vol_step) : (vol_cur - vol_step);
      volume_in   = volume_ff;
      position_in = position_ff;
      if (in_ff.rotated) begin
         if (select_ff) begin
            if (vol_sum >= vol_bound) begin
               volume_in = vol_max_ff;
            end else if (vol_sum <= 0) begin
               volume_in = '0;
            end else begin
               volume_in = vol_sum[ccm_pkg::VolWidth-1:0];
            end
         end else begin
            position_in = in_ff.turn_up ? (position_ff + 1'b1) : (position_ff - 1'b1);
         end
      end

      // A long click on any channel enters select mode; an encoder short click
      // ends it, even in the same pass.
      select_in = select_ff | (|clicks.long_clicks[ccm_pkg::NumChannels-1:0]);
      if (enc_short) begin
         select_in = 1'b0;
      end

      sel_mask = '0;
      mutes    = '0;
      unmutes  = '0;
      led_in   = led_ff;
      for (int i = 0; i < ccm_pkg::NumChannels; i++) begin
         mode_in[i]  = mode_ff[i];
         prev_eff[i] = prev_ff[i];
         if (clicks.short_clicks[i]) begin
            mode_in[i] = led_ff[i] ? ccm_pkg::MODE_MUTED : ccm_pkg::MODE_UNMUTED;
         end
         if (clicks.long_clicks[i]) begin
            mode_in[i] = ccm_pkg::MODE_SELECT;
         end
         // Leaving select through the encoder always reports an unmute.
         if (enc_short && mode_in[i] == ccm_pkg::MODE_SELECT) begin
            prev_eff[i] = ccm_pkg::MODE_SELECT;
            mode_in[i]  = ccm_pkg::MODE_UNMUTED;
         end
         if (mode_in[i] != prev_eff[i]) begin
            if (mode_in[i] == ccm_pkg::MODE_UNMUTED) begin
               led_in[i]  = 1'b1;
               unmutes[i] = 1'b1;
            end else if (mode_in[i] == ccm_pkg::MODE_MUTED) begin
               led_in[i] = 1'b0;
               mutes[i]  = 1'b1;
            end
         end
         sel_mask[i] = (mode_in[i] == ccm_pkg::MODE_SELECT);
      end

      out_in.short_clicks     = clicks.short_clicks;
      out_in.long_clicks      = clicks.long_clicks;
      out_in.led_on           = led_in;
      out_in.select_mask      = sel_mask;
      out_in.mute_events      = mutes;
      out_in.unmute_events    = unmutes;
      out_in.select_active    = select_in;
      out_in.volume_level     = volume_in;
      out_in.encoder_position = $signed(position_in);
   end

   // Input register: loads whenever it is free or being emptied.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // Channel state commits with the pass. Previous modes start muted so the first pass
   // reports each channel without a click as unmuted and lights its LED.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ccm_pkg::NumChannels; i++) begin
            mode_ff[i] <= ccm_pkg::MODE_UNMUTED;
            prev_ff[i] <= ccm_pkg::MODE_MUTED;
         end
         led_ff      <= '0;
         select_ff   <= 1'b0;
         volume_ff   <= ccm_pkg::VolumeReset;
         position_ff <= '0;
      end else if (advance) begin
         for (int i = 0; i < ccm_pkg::NumChannels; i++) begin
            mode_ff[i] <= mode_in[i];
            prev_ff[i] <= mode_in[i];
         end
         led_ff      <= led_in;
         select_ff   <= select_in;
         volume_ff   <= volume_in;
         position_ff <= position_in;
      end
   end

endmodule
